// File: hdl/kvmm_pkg.sv
package kvmm_pkg;

  localparam int KIND_W  = 2;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic        [DATA_W-1:0] age;
  } entry_t;

endpackage

// File: hdl/key_value_multimap_table.sv
// Every request walks all TABLE_DEPTH slots of the entry memory, one read per cycle.
// The result strobe rises after the scan, the tail state for the last compare and the
// commit state (S_SCAN, S_TAIL, S_FIN); busy falls with the strobe, so a new request
// is taken only once the previous result is out. The receiver cannot stall the output.
// Synchronous active-low reset empties the table and clears the count and insert stamp;
// the entry memory is not cleared, as slot contents are only used where marked valid.
module key_value_multimap_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic        [kvmm_pkg::KIND_W-1:0]     in_kind,
  input  logic signed [kvmm_pkg::DATA_W-1:0]     in_key,
  input  logic signed [kvmm_pkg::DATA_W-1:0]     in_value,
  output logic                                   out_valid,
  output logic        [kvmm_pkg::STAT_W-1:0]     out_status,
  output logic signed [kvmm_pkg::DATA_W-1:0]     out_found_value,
  output logic        [kvmm_pkg::COUNT_W-1:0]    out_entry_count
);
  import kvmm_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [IDX_W-1:0]         addr_r;
  logic                     cmp_vld_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  entry_t                   rd_q;
  entry_t                   mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [DATA_W-1:0]        stamp_r, stamp_nxt;

  logic [KIND_W-1:0]        req_kind_r;
  logic signed [DATA_W-1:0] req_key_r;
  logic signed [DATA_W-1:0] req_value_r;

  logic                     best_hit_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [DATA_W-1:0]        best_dist_r;
  logic signed [DATA_W-1:0] best_val_r;
  logic                     free_hit_r;
  logic [IDX_W-1:0]         free_idx_r;

  logic                     accept;
  logic                     cmp_valid_slot;
  logic                     cmp_hit;
  logic [DATA_W-1:0]        cmp_dist;
  logic                     mem_we;
  entry_t                   mem_wd;
  logic [STAT_W-1:0]        fin_status;
  logic signed [DATA_W-1:0] fin_value;
  logic                     fin_set, fin_clr;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign cmp_valid_slot = valid_r[cmp_idx_r];
  assign cmp_hit        = cmp_valid_slot && (rd_q.key == req_key_r);
  assign cmp_dist       = stamp_r - rd_q.age;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_SCAN;
      S_SCAN: if (addr_r == LAST_IDX) state_nxt = S_TAIL;
      S_TAIL: state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commit decisions, taken in the final cycle once the whole table has been seen.
  always_comb begin
    fin_status = ST_OK;
    fin_value  = '0;
    fin_set    = 1'b0;
    fin_clr    = 1'b0;
    count_nxt  = count_r;
    stamp_nxt  = stamp_r;
    unique case (req_kind_r)
      KIND_INSERT: begin
        if (free_hit_r) begin
          fin_set   = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          stamp_nxt = stamp_r + DATA_W'(1);
        end else begin
          fin_status = ST_FULL;
        end
      end
      KIND_FIND: begin
        if (best_hit_r) begin
          fin_value = best_val_r;
        end else begin
          fin_status = ST_MISSING;
        end
      end
      KIND_ERASE: begin
        if (best_hit_r) begin
          fin_clr = 1'b1;
          if (count_r != '0) count_nxt = count_r - CNT_W'(1);
        end else begin
          fin_status = ST_MISSING;
        end
      end
      default: fin_status = ST_OK;
    endcase
  end

  assign mem_we       = (state_r == S_FIN) && fin_set;
  assign mem_wd.key   = req_key_r;
  assign mem_wd.value = req_value_r;
  assign mem_wd.age   = stamp_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) mem[free_idx_r] <= mem_wd;
    rd_q <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      addr_r     <= '0;
      cmp_vld_r  <= 1'b0;
      valid_r    <= '0;
      count_r    <= '0;
      stamp_r    <= '0;
      best_hit_r <= 1'b0;
      free_hit_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      cmp_vld_r <= (state_r == S_SCAN);
      if (accept) begin
        addr_r     <= '0;
        best_hit_r <= 1'b0;
        free_hit_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        addr_r <= addr_r + IDX_W'(1);
      end
      if (cmp_vld_r) begin
        if (cmp_hit && (!best_hit_r || (cmp_dist < best_dist_r))) begin
          best_hit_r <= 1'b1;
        end
        if (!cmp_valid_slot && !free_hit_r) begin
          free_hit_r <= 1'b1;
        end
      end
      if (state_r == S_FIN) begin
        count_r   <= count_nxt;
        stamp_r   <= stamp_nxt;
        out_valid <= 1'b1;
        if (fin_set) valid_r[free_idx_r] <= 1'b1;
        if (fin_clr) valid_r[best_idx_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
    if (accept) begin
      req_kind_r  <= in_kind;
      req_key_r   <= in_key;
      req_value_r <= in_value;
    end
    if (cmp_vld_r && cmp_hit && (!best_hit_r || (cmp_dist < best_dist_r))) begin
      best_idx_r  <= cmp_idx_r;
      best_dist_r <= cmp_dist;
      best_val_r  <= rd_q.value;
    end
    if (cmp_vld_r && !cmp_valid_slot && !free_hit_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (state_r == S_FIN) begin
      out_status      <= fin_status;
      out_found_value <= fin_value;
      out_entry_count <= COUNT_W'(count_nxt);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count disagrees with valid slots");

  a_strobe_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_FIN))
    else $error("result strobe without a commit cycle");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy && !out_valid))
    else $error("accepted request did not start a scan");

  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !(fin_set && fin_clr))
    else $error("insert and erase committed together");

endmodule
